/* hw/rtl/csb_pkg.sv */
// ----------------------------------------------------------------------------
// csb_pkg: shared types and constants for the clipped sprite blitter
// Register indexes, operation codes, the command passed from the front end
// to the back end through the command queue, and fixed field widths.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int CFG_W      = 11;
  localparam int IDX_W      = 3;
  localparam int OP_W       = 3;
  localparam int PIX_W      = 8;
  localparam int LOC_W      = 16;
  localparam int PROD_W     = 2 * CFG_W;
  localparam int FADDR_W    = PROD_W + 1;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 16;
  localparam int BLEND_DEPTH = 65536;
  localparam int MASK_DEPTH  = 256;
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_PLACE_X       = 3'd4;
  localparam logic [IDX_W-1:0] REG_PLACE_Y       = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLEND_MODE    = 3'd6;
  localparam logic [IDX_W-1:0] REG_MASK_ENABLE   = 3'd7;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd320;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd200;
  localparam logic [CFG_W-1:0] RST_SPRITE_DIM   = 11'd1;

  // input operation codes
  localparam logic [OP_W-1:0] OP_PIXEL       = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_BLEND  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_MASK   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_FRAME = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_FRAME  = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DRAW,
    CMD_LOAD_BLEND,
    CMD_LOAD_MASK,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PIX_W-1:0]   pix;
    logic [LOC_W-1:0]   loc;
    logic               blend;
    logic               mask_chk;
    logic               done;
  } cmd_t;

endpackage

/* hw/rtl/clipped_sprite_blit_top.sv */
// ----------------------------------------------------------------------------
// clipped_sprite_blit_top: clipped sprite blitter, 8-bit indexed frame buffer
// Input beats on the s_ channel carry an operation (s_tuser) with a pixel or
// data byte and a location (s_tdata): sprite pixels in raster order, loads of
// the translucency table and protect mask, frame writes and frame reads.
// Every input beat yields exactly one m_ beat carrying the read byte and the
// drawn flag; m_tlast marks the last pixel of a sprite raster.
// Configuration registers are written on the cfg_ port, one register per
// cycle, no read-back; the user must write them only while the block is idle,
// which the block itself does not enforce. The block takes one beat per cycle:
// the front end clips and computes the frame address, a four-entry queue
// decouples it from the back end, whose frame RAM read-modify-write runs one
// beat per cycle with bypass of pending writes. When the receiver stalls, the
// back end holds and the queue fills; s_tready drops once the queue and the
// front end register are full. Reset clears the configuration to its defaults
// and the raster position and empties the pipeline; the back end then clears
// the protect mask, during which up to five beats are accepted and held. Frame
// buffer and table contents are undefined until written.
// ----------------------------------------------------------------------------
module clipped_sprite_blit_top #(
  parameter int FRAME_BYTES = 65536,
  parameter int MAX_DIM     = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [csb_pkg::S_TDATA_W-1:0]     s_tdata,   // pixel[7:0], location[23:8]
  input  logic [csb_pkg::OP_W-1:0]          s_tuser,   // operation[2:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [csb_pkg::M_TDATA_W-1:0]     m_tdata,   // read_data[7:0], drawn[8], zero
  output logic                              m_tlast,
  input  logic                              cfg_write,
  input  logic [csb_pkg::IDX_W-1:0]         cfg_index,
  input  logic [csb_pkg::CFG_W-1:0]         cfg_data
);
  import csb_pkg::*;

  localparam int AW    = $clog2(FRAME_BYTES);
  localparam int CMD_W = $bits(cmd_t);
  localparam int QW    = CMD_W + AW;

  logic              f_push, q_full, q_empty, q_pop;
  cmd_t              f_cmd, b_cmd;
  logic [AW-1:0]     f_addr, b_addr;
  logic [QW-1:0]     q_din, q_dout;
  logic [PIX_W-1:0]  read_data;
  logic              drawn;

  csb_front #(.FRAME_BYTES(FRAME_BYTES), .MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_pix    (s_tdata[PIX_W-1:0]),
    .in_loc    (s_tdata[PIX_W+LOC_W-1:PIX_W]),
    .q_push    (f_push),
    .q_full    (q_full),
    .q_cmd     (f_cmd),
    .q_addr    (f_addr)
  );

  assign q_din = {f_addr, f_cmd};

  csb_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign b_cmd  = cmd_t'(q_dout[CMD_W-1:0]);
  assign b_addr = q_dout[QW-1:CMD_W];

  csb_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_cmd         (b_cmd),
    .q_addr        (b_addr),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_read_data (read_data),
    .out_drawn     (drawn),
    .out_done      (m_tlast)
  );

  assign m_tdata = {(M_TDATA_W - PIX_W - 1)'(0), drawn, read_data};

endmodule

/* hw/rtl/csb_ram.sv */
// ----------------------------------------------------------------------------
// csb_ram: generic single write port, single read port RAM
// Registered read with read enable; a read at the written address returns
// the old contents.
// ----------------------------------------------------------------------------
module csb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/csb_queue.sv */
// ----------------------------------------------------------------------------
// csb_queue: short command queue between front end and back end
// Register-based FIFO, first-word fall-through, push and pop in the same cycle.
// ----------------------------------------------------------------------------
module csb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, wr_ptr_next;
  logic [PW-1:0]    rd_ptr, rd_ptr_next;
  logic [CNTW-1:0]  count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  push_not_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  pop_not_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");

endmodule

/* hw/rtl/csb_front.sv */
// ----------------------------------------------------------------------------
// csb_front: configuration, raster tracking and clipping
// Holds the configuration registers and the sprite raster position, decodes
// each input beat into a command, clips sprite pixels and forms the frame
// address (multiply registered, add and range check on the way out).
// ----------------------------------------------------------------------------
module csb_front #(
  parameter int FRAME_BYTES = 65536,
  parameter int MAX_DIM     = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [csb_pkg::IDX_W-1:0]     cfg_index,
  input  logic [csb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csb_pkg::OP_W-1:0]      in_op,
  input  logic [csb_pkg::PIX_W-1:0]     in_pix,
  input  logic [csb_pkg::LOC_W-1:0]     in_loc,
  output logic                          q_push,
  input  logic                          q_full,
  output csb_pkg::cmd_t                 q_cmd,
  output logic [$clog2(FRAME_BYTES)-1:0] q_addr
);
  import csb_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int XW = DW + 1;
  localparam logic [DW-1:0]      DIM_MAX = DW'(MAX_DIM);
  localparam logic [FADDR_W-1:0] FB_LIM  = FADDR_W'(FRAME_BYTES);

  logic [CFG_W-1:0] frame_width, frame_height, sprite_width, sprite_height;
  logic [CFG_W-1:0] place_x, place_y;
  logic [1:0]       blend_mode;
  logic             mask_enable;
  logic [CW-1:0]    sprite_col, sprite_row;

  logic             a_valid;
  cmd_t             a_cmd;
  logic [CFG_W-1:0] a_fx;
  logic [PROD_W-1:0] a_prod;

  logic             take;
  logic [DW-1:0]    w_eff, h_eff, col_inc, row_inc;
  logic             col_last, row_last;
  logic [XW-1:0]    fx, fy;
  logic             x_in, y_in, keyed_zero, loc_ok;
  cmd_t             cmd;
  logic [FADDR_W-1:0] addr_full;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (DW'(d) > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = DW'(d);
    end
    return r;
  endfunction

  assign in_ready = !a_valid || !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    w_eff    = eff_dim(sprite_width);
    h_eff    = eff_dim(sprite_height);
    col_inc  = DW'(sprite_col) + DW'(1);
    row_inc  = DW'(sprite_row) + DW'(1);
    col_last = (col_inc >= w_eff);
    row_last = (row_inc >= h_eff);

    fx = {{(XW - CFG_W){place_x[CFG_W-1]}}, place_x} + XW'(sprite_col);
    fy = {{(XW - CFG_W){place_y[CFG_W-1]}}, place_y} + XW'(sprite_row);
    x_in = !fx[XW-1] && (fx < XW'(frame_width));
    y_in = !fy[XW-1] && (fy < XW'(frame_height));
    keyed_zero = !blend_mode[1] && (in_pix == '0);
    loc_ok = (FADDR_W'(in_loc) < FB_LIM);

    cmd.pix      = in_pix;
    cmd.loc      = in_loc;
    cmd.blend    = blend_mode[0];
    cmd.mask_chk = mask_enable;
    cmd.done     = (in_op == OP_PIXEL) && col_last && row_last;
    case (in_op)
      OP_PIXEL:       cmd.kind = (x_in && y_in && !keyed_zero) ? CMD_DRAW : CMD_NONE;
      OP_LOAD_BLEND:  cmd.kind = CMD_LOAD_BLEND;
      OP_LOAD_MASK:   cmd.kind = (in_loc < LOC_W'(MASK_DEPTH)) ? CMD_LOAD_MASK : CMD_NONE;
      OP_WRITE_FRAME: cmd.kind = loc_ok ? CMD_WRITE : CMD_NONE;
      OP_READ_FRAME:  cmd.kind = loc_ok ? CMD_READ : CMD_NONE;
      default:        cmd.kind = CMD_NONE;
    endcase
  end

  // configuration and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      sprite_width  <= RST_SPRITE_DIM;
      sprite_height <= RST_SPRITE_DIM;
      place_x       <= '0;
      place_y       <= '0;
      blend_mode    <= '0;
      mask_enable   <= 1'b0;
      sprite_col    <= '0;
      sprite_row    <= '0;
      a_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   frame_width   <= cfg_data;
          REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
          REG_SPRITE_WIDTH:  sprite_width  <= cfg_data;
          REG_SPRITE_HEIGHT: sprite_height <= cfg_data;
          REG_PLACE_X:       place_x       <= cfg_data;
          REG_PLACE_Y:       place_y       <= cfg_data;
          REG_BLEND_MODE:    blend_mode    <= cfg_data[1:0];
          REG_MASK_ENABLE:   mask_enable   <= cfg_data[0];
          default:           mask_enable   <= mask_enable;
        endcase
      end
      if (take && (in_op == OP_PIXEL)) begin
        if (col_last) begin
          sprite_col <= '0;
          sprite_row <= row_last ? '0 : row_inc[CW-1:0];
        end else begin
          sprite_col <= col_inc[CW-1:0];
        end
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_cmd  <= cmd;
      a_fx   <= fx[CFG_W-1:0];
      a_prod <= fy[CFG_W-1:0] * frame_width;
    end
  end

  // frame address and range check
  always_comb begin
    addr_full = FADDR_W'(a_prod) + FADDR_W'(a_fx);
    q_cmd     = a_cmd;
    if ((a_cmd.kind == CMD_DRAW) && (addr_full >= FB_LIM)) begin
      q_cmd.kind = CMD_NONE;
    end
    q_addr = (a_cmd.kind == CMD_DRAW) ? AW'(addr_full) : AW'(a_cmd.loc);
  end

  assign q_push = a_valid && !q_full;

  held_cmd_kept: assert property (@(posedge clk) disable iff (rst)
    a_valid && q_full |=> a_valid && $stable(a_cmd))
    else $error("command dropped while queue full");

endmodule

/* hw/rtl/csb_back.sv */
// ----------------------------------------------------------------------------
// csb_back: frame read-modify-write pipeline
// Stage 2 gets the destination byte (with bypass of frame writes not yet
// visible in the RAM) and issues the protect mask and blend lookups; stage 3
// applies the mask, writes the frame and holds the result beat. After reset
// the protect mask RAM is cleared before any beat is taken.
// ----------------------------------------------------------------------------
module csb_back #(
  parameter int FRAME_BYTES = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  csb_pkg::cmd_t                  q_cmd,
  input  logic [$clog2(FRAME_BYTES)-1:0] q_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csb_pkg::PIX_W-1:0]      out_read_data,
  output logic                           out_drawn,
  output logic                           out_done
);
  import csb_pkg::*;

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int MAW = $clog2(MASK_DEPTH);

  logic              adv, q_ok;
  logic              s2_valid;
  cmd_t              s2_cmd;
  logic [AW-1:0]     s2_addr;

  logic              s3_valid, s3_wr, s3_blend, s3_drawn, s3_done;
  logic              s3_draw, s3_mask_chk, s3_write;
  logic [PIX_W-1:0]  s3_pix, s3_read_data;
  logic [AW-1:0]     s3_addr;

  logic              hold_valid;
  logic [AW-1:0]     hold_addr;
  logic [PIX_W-1:0]  hold_data;

  logic              clearing;
  logic [MAW-1:0]    clr_addr;

  logic [PIX_W-1:0]  frame_rdata, blend_rdata, fr_wdata, dst;
  logic              fr_we, bl_we, mask_we, mask_wr, mask_wdata, mask_rdata;
  logic [MAW-1:0]    mask_waddr;

  assign adv   = !s3_valid || out_ready;
  assign q_ok  = !q_empty && !clearing;
  assign q_pop = adv && q_ok;

  assign s3_drawn = s3_draw && !(s3_mask_chk && mask_rdata);
  assign s3_wr    = s3_drawn || s3_write;

  assign fr_wdata = s3_blend ? blend_rdata : s3_pix;
  assign fr_we    = adv && s3_valid && s3_wr;
  assign bl_we    = adv && s2_valid && (s2_cmd.kind == CMD_LOAD_BLEND);
  assign mask_we  = adv && s2_valid && (s2_cmd.kind == CMD_LOAD_MASK);

  // clearing pass owns the mask write port
  assign mask_wr    = mask_we || clearing;
  assign mask_waddr = clearing ? clr_addr : s2_cmd.loc[MAW-1:0];
  assign mask_wdata = !clearing && s2_cmd.pix[0];

  always_comb begin
    if (s3_valid && s3_wr && (s3_addr == s2_addr)) begin
      dst = fr_wdata;
    end else if (hold_valid && (hold_addr == s2_addr)) begin
      dst = hold_data;
    end else begin
      dst = frame_rdata;
    end
  end

  csb_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_BYTES)) u_frame (
    .clk   (clk),
    .we    (fr_we),
    .waddr (s3_addr),
    .wdata (fr_wdata),
    .re    (adv),
    .raddr (q_addr),
    .rdata (frame_rdata)
  );

  csb_ram #(.WIDTH(PIX_W), .DEPTH(BLEND_DEPTH)) u_blend (
    .clk   (clk),
    .we    (bl_we),
    .waddr (s2_cmd.loc),
    .wdata (s2_cmd.pix),
    .re    (adv),
    .raddr ({s2_cmd.pix, dst}),
    .rdata (blend_rdata)
  );

  csb_ram #(.WIDTH(1), .DEPTH(MASK_DEPTH)) u_mask (
    .clk   (clk),
    .we    (mask_wr),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .re    (adv),
    .raddr (dst),
    .rdata (mask_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      hold_valid <= 1'b0;
      clearing   <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == MAW'(MASK_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (adv) begin
        s2_valid   <= q_ok;
        s3_valid   <= s2_valid;
        hold_valid <= fr_we;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd       <= q_cmd;
      s2_addr      <= q_addr;
      s3_draw      <= (s2_cmd.kind == CMD_DRAW);
      s3_mask_chk  <= s2_cmd.mask_chk;
      s3_write     <= (s2_cmd.kind == CMD_WRITE);
      s3_blend     <= s2_cmd.blend && (s2_cmd.kind == CMD_DRAW);
      s3_done      <= s2_cmd.done;
      s3_pix       <= s2_cmd.pix;
      s3_addr      <= s2_addr;
      s3_read_data <= (s2_cmd.kind == CMD_READ) ? dst : '0;
      hold_addr    <= s3_addr;
      hold_data    <= fr_wdata;
    end
  end

  assign out_valid     = s3_valid;
  assign out_read_data = s3_read_data;
  assign out_drawn     = s3_drawn;
  assign out_done      = s3_done;

  hold_tracks_write: assert property (@(posedge clk) disable iff (rst)
    fr_we |=> hold_valid && (hold_addr == $past(s3_addr)))
    else $error("bypass register missed a frame write");
  read_never_writes: assert property (@(posedge clk) disable iff (rst)
    s3_valid && (s3_read_data != '0) |-> !s3_wr)
    else $error("read beat marked as frame write");
  no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("queue popped during mask clear");

endmodule
